// ----- sv/pal_pkg.sv -----
// Shared types and constants for the positional array list.
package pal_pkg;

  localparam int DEF_CAPACITY  = 128;
  localparam int DEF_WORD_BITS = 32;
  localparam int POS_BITS      = 8;
  localparam int DIN_BITS      = 32;

  typedef enum logic [2:0] {
    FN_READ   = 3'd0,
    FN_WRITE  = 3'd1,
    FN_INSERT = 3'd2,
    FN_ERASE  = 3'd3,
    FN_FIND   = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT_UP,
    S_PLACE,
    S_SHIFT_DN,
    S_FIND,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]          func;
    logic [POS_BITS-1:0] position;
    logic [DIN_BITS-1:0] data_in;
  } pal_in_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] data_out;
    logic [6:0]  found_index;
    logic [7:0]  list_length;
  } pal_out_t;

endpackage

// ----- sv/pal_mem.sv -----
// Word storage: one write port and one registered read port.
module pal_mem import pal_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int WORD_BITS = DEF_WORD_BITS,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [CAPACITY];
  logic [WORD_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/pal_ctrl.sv -----
// Operation sequencer: decodes a request and walks the memory for shifts and searches.
module pal_ctrl import pal_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int WORD_BITS = DEF_WORD_BITS,
  localparam int AW   = $clog2(CAPACITY),
  localparam int CW   = $clog2(CAPACITY + 1),
  localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS,
  localparam int DW   = (WORD_BITS > DIN_BITS) ? WORD_BITS : DIN_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  pal_in_t              in_item,
  output logic                 in_ready,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [WORD_BITS-1:0] mem_wdata,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  input  logic [WORD_BITS-1:0] mem_rdata,
  input  logic                 res_take,
  output logic                 res_valid,
  output pal_out_t             res
);

  state_t               state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [WORD_BITS-1:0] key_r, key_nxt;
  pal_out_t             res_r, res_nxt;

  logic [CMPW-1:0]      pos_ext;
  logic [CMPW-1:0]      cnt_ext;
  logic [AW-1:0]        pos_a;
  logic [AW-1:0]        cnt_a;
  logic [CW-1:0]        cnt_inc;
  logic [CW-1:0]        cnt_dec;
  logic [DW-1:0]        din_ext;
  logic [WORD_BITS-1:0] din_w;
  logic [DW-1:0]        rd_ext;
  logic [CW:0]          idx_p1;
  logic [CW:0]          idx_p2;
  logic [CW:0]          cnt_w;

  assign pos_ext = CMPW'(in_item.position);
  assign cnt_ext = CMPW'(cnt_r);
  assign pos_a   = pos_ext[AW-1:0];
  assign cnt_a   = cnt_r[AW-1:0];
  assign cnt_inc = cnt_r + CW'(1);
  assign cnt_dec = cnt_r - CW'(1);
  assign din_ext = DW'(in_item.data_in);
  assign din_w   = din_ext[WORD_BITS-1:0];
  assign rd_ext  = DW'(mem_rdata);
  assign idx_p1  = (CW+1)'(idx_r) + (CW+1)'(1);
  assign idx_p2  = (CW+1)'(idx_r) + (CW+1)'(2);
  assign cnt_w   = (CW+1)'(cnt_r);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    key_nxt   = key_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_nxt                 = pos_a;
          key_nxt                 = din_w;
          res_nxt.status          = ST_OK;
          res_nxt.data_out        = '0;
          res_nxt.found_index     = '0;
          res_nxt.list_length     = 8'(cnt_r);
          state_nxt               = S_DONE;
          case (in_item.func)
            FN_READ: begin
              if (pos_ext < cnt_ext) begin
                mem_re    = 1'b1;
                mem_raddr = pos_a;
                state_nxt = S_READ;
              end else begin
                res_nxt.status = ST_RANGE;
              end
            end
            FN_WRITE: begin
              if (pos_ext < cnt_ext) begin
                mem_we    = 1'b1;
                mem_waddr = pos_a;
                mem_wdata = din_w;
              end else begin
                res_nxt.status = ST_RANGE;
              end
            end
            FN_INSERT: begin
              if (pos_ext > cnt_ext) begin
                res_nxt.status = ST_RANGE;
              end else if (cnt_ext == CMPW'(CAPACITY)) begin
                res_nxt.status = ST_FULL;
              end else if (pos_ext == cnt_ext) begin
                // Appending at the tail needs no shift.
                mem_we              = 1'b1;
                mem_waddr           = pos_a;
                mem_wdata           = din_w;
                cnt_nxt             = cnt_inc;
                res_nxt.list_length = 8'(cnt_inc);
              end else begin
                // Move words up starting from the tail; each read word arrives in the next cycle.
                mem_re    = 1'b1;
                mem_raddr = cnt_a - AW'(1);
                idx_nxt   = cnt_a;
                state_nxt = S_SHIFT_UP;
              end
            end
            FN_ERASE: begin
              if (pos_ext >= cnt_ext) begin
                res_nxt.status = ST_RANGE;
              end else if (pos_ext == cnt_ext - CMPW'(1)) begin
                cnt_nxt             = cnt_dec;
                res_nxt.list_length = 8'(cnt_dec);
              end else begin
                mem_re    = 1'b1;
                mem_raddr = pos_a + AW'(1);
                idx_nxt   = pos_a;
                state_nxt = S_SHIFT_DN;
              end
            end
            FN_FIND: begin
              if (cnt_r == '0) begin
                res_nxt.status = ST_MISSING;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                idx_nxt   = '0;
                state_nxt = S_FIND;
              end
            end
            default: begin
              res_nxt.status = ST_RANGE;
            end
          endcase
        end
      end
      S_READ: begin
        res_nxt.data_out = rd_ext[31:0];
        state_nxt        = S_DONE;
      end
      S_SHIFT_UP: begin
        // The write target sits two entries above the next read, so they never collide.
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        if ((idx_r - AW'(1)) > pos_r) begin
          mem_re    = 1'b1;
          mem_raddr = idx_r - AW'(2);
          idx_nxt   = idx_r - AW'(1);
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        mem_we              = 1'b1;
        mem_waddr           = pos_r;
        mem_wdata           = key_r;
        cnt_nxt             = cnt_inc;
        res_nxt.list_length = 8'(cnt_inc);
        state_nxt           = S_DONE;
      end
      S_SHIFT_DN: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        if (idx_p2 < cnt_w) begin
          mem_re    = 1'b1;
          mem_raddr = idx_r + AW'(2);
          idx_nxt   = idx_r + AW'(1);
        end else begin
          cnt_nxt             = cnt_dec;
          res_nxt.list_length = 8'(cnt_dec);
          state_nxt           = S_DONE;
        end
      end
      S_FIND: begin
        if (mem_rdata == key_r) begin
          res_nxt.status      = ST_OK;
          res_nxt.found_index = 7'(idx_r);
          state_nxt           = S_DONE;
        end else if (idx_p1 < cnt_w) begin
          mem_re    = 1'b1;
          mem_raddr = idx_r + AW'(1);
          idx_nxt   = idx_r + AW'(1);
        end else begin
          res_nxt.status = ST_MISSING;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/positional_array_list.sv -----
// Ordered list of up to CAPACITY words with read, write, insert, erase and find requests.
//
// Usage: a request transaction on in_valid/in_ready carries func, position and
// data_in; exactly one response transaction follows on out_valid/out_ready with
// status, data_out, found_index and the list length after the operation.
// Requests are handled one at a time; in_ready is high whenever the sequencer
// is idle, even while the previous response still waits in the output register.
// Steps from request to response being loaded into the output register:
//   write, failed requests, tail insert, tail erase: result set directly
//   read: one memory read state, as the read port is registered
//   insert at position p with length n: words p..n-1 move up from the tail, then p is written
//   erase at position p with length n: words p+1..n-1 move down by one
//   find: scans from index 0, ending early at the first match.
// The memory has a single write port and a single read port, so shifts and
// searches move one word per cycle.
// Reset clears the length and the sequencer; word storage is not cleared.
// A stalled receiver holds the response; the next request's result then waits in the
// final sequencer state until the output register frees up.
module positional_array_list import pal_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pal_in_t  in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output pal_out_t out_item
);

  localparam int AW = $clog2(CAPACITY);

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;
  logic                 res_take;
  logic                 res_valid;
  pal_out_t             res;

  logic                 out_valid_r, out_valid_nxt;
  pal_out_t             out_item_r;

  pal_ctrl #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_ready  (in_ready),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_take  (res_take),
    .res_valid (res_valid),
    .res       (res)
  );

  pal_mem #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_take = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid && res_take) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
